### rtl/core/frasm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frasm_pkg: shared types and constants for the fragment reassembler
// Holds the buffer geometry, status and frame-kind codes, register indexes
// and the structs that connect the register file, controller and store.
// ----------------------------------------------------------------------------
package frasm_pkg;

  localparam int unsigned BUFFER_DEPTH    = 1024;
  localparam int unsigned BUF_AW          = $clog2(BUFFER_DEPTH);
  localparam int unsigned FIRST_HDR_BYTES = 5;
  localparam int unsigned CONT_HDR_BYTES  = 1;
  localparam int unsigned LEN_W           = 11;
  localparam int unsigned POS_W           = 3;
  localparam int unsigned POS_MAX         = 7;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned APB_AW          = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_TIMEOUT     = 3'd0;
  localparam logic [2:0] REG_CAPACITY    = 3'd1;
  localparam logic [2:0] REG_CODE_SINGLE = 3'd2;
  localparam logic [2:0] REG_CODE_FIRST  = 3'd3;
  localparam logic [2:0] REG_CODE_MIDDLE = 3'd4;
  localparam logic [2:0] REG_CODE_END    = 3'd5;

  typedef enum logic [1:0] {
    ST_MORE    = 2'd0,
    ST_DELIVER = 2'd1,
    ST_DROP    = 2'd2,
    ST_READ    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_SINGLE = 3'd1,
    KIND_FIRST  = 3'd2,
    KIND_MIDDLE = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [31:0]      timeout_limit;
    logic [LEN_W-1:0] capacity;
    logic [7:0]       code_single;
    logic [7:0]       code_first;
    logic [7:0]       code_middle;
    logic [7:0]       code_end;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic [BUF_AW-1:0] addr;
  } store_rd_t;

endpackage

### rtl/core/frasm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frasm_regs: configuration register file
// APB-style slave holding the timeout, capacity and the four control codes.
// ----------------------------------------------------------------------------
module frasm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frasm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output frasm_pkg::cfg_t               cfg_o
);
  import frasm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT:     cfg_d.timeout_limit = pwdata;
        REG_CAPACITY:    cfg_d.capacity      = pwdata[LEN_W-1:0];
        REG_CODE_SINGLE: cfg_d.code_single   = pwdata[7:0];
        REG_CODE_FIRST:  cfg_d.code_first    = pwdata[7:0];
        REG_CODE_MIDDLE: cfg_d.code_middle   = pwdata[7:0];
        REG_CODE_END:    cfg_d.code_end      = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT:     prdata = cfg_q.timeout_limit;
      REG_CAPACITY:    prdata = 32'(cfg_q.capacity);
      REG_CODE_SINGLE: prdata = 32'(cfg_q.code_single);
      REG_CODE_FIRST:  prdata = 32'(cfg_q.code_first);
      REG_CODE_MIDDLE: prdata = 32'(cfg_q.code_middle);
      REG_CODE_END:    prdata = 32'(cfg_q.code_end);
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_limit <= 32'd0;
      cfg_q.capacity      <= LEN_W'(BUFFER_DEPTH);
      cfg_q.code_single   <= 8'd0;
      cfg_q.code_first    <= 8'd1;
      cfg_q.code_middle   <= 8'd2;
      cfg_q.code_end      <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/frasm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frasm_store: message buffer
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frasm_store (
  input  logic                  clk_i,
  input  frasm_pkg::store_wr_t  wr_i,
  input  frasm_pkg::store_rd_t  rd_i,
  output logic [7:0]            rdata_o
);
  import frasm_pkg::*;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/frasm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frasm_ctrl: frame parser and reassembly controller
// Parses each PDU byte, updates the reassembly state, drives the buffer
// ports and holds the result word in an output register.
// ----------------------------------------------------------------------------
module frasm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frasm_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          pdu_last_i,
  input  logic [31:0]                   now_ms_i,
  input  logic [frasm_pkg::IDX_W-1:0]   read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [frasm_pkg::LEN_W-1:0]   message_length_o,
  output logic [7:0]                    read_data_o,
  output frasm_pkg::store_wr_t          store_wr_o,
  output frasm_pkg::store_rd_t          store_rd_o,
  input  logic [7:0]                    store_rdata_i
);
  import frasm_pkg::*;

  logic             reasm_q, reasm_d;
  logic [LEN_W-1:0] exp_total_q, exp_total_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [31:0]      last_time_q, last_time_d;
  kind_e            kind_q, kind_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      len_shift_q, len_shift_d;
  logic [31:0]      frame_time_q, frame_time_d;
  logic             bad_q, bad_d;

  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             rd_zero_q, rd_zero_d;

  logic             in_accept;
  logic             out_load;
  logic [31:0]      eff_cap;
  logic             take;
  logic             hdr_ok;

  assign in_accept  = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i || (!cmd_i && !pdu_last_i);
  assign out_load   = in_accept && (cmd_i || pdu_last_i);
  assign eff_cap    = (32'(cfg_i.capacity) < BUFFER_DEPTH) ? 32'(cfg_i.capacity)
                                                           : 32'(BUFFER_DEPTH);

  assign store_rd_o.re   = in_accept && cmd_i;
  assign store_rd_o.addr = BUF_AW'(read_index_i);

  always_comb begin
    reasm_d      = reasm_q;
    exp_total_d  = exp_total_q;
    fill_d       = fill_q;
    last_time_d  = last_time_q;
    kind_d       = kind_q;
    pos_d        = pos_q;
    len_shift_d  = len_shift_q;
    frame_time_d = frame_time_q;
    bad_d        = bad_q;
    take         = 1'b0;
    hdr_ok       = 1'b0;
    store_wr_o   = '0;
    status_d     = ST_DROP;
    len_d        = '0;
    rd_zero_d    = 1'b0;

    if (in_accept && cmd_i) begin
      status_d  = ST_READ;
      rd_zero_d = !(32'(read_index_i) < BUFFER_DEPTH);
    end else if (in_accept) begin
      if (pos_q == '0) begin
        // Control byte: check the gap since the last accepted frame first.
        if (reasm_q && (cfg_i.timeout_limit != 32'd0) &&
            ((now_ms_i - last_time_q) > cfg_i.timeout_limit)) begin
          reasm_d     = 1'b0;
          exp_total_d = '0;
          fill_d      = '0;
        end
        frame_time_d = now_ms_i;
        bad_d        = 1'b0;
        priority if (data_byte_i == cfg_i.code_single) begin
          kind_d = KIND_SINGLE;
        end else if (data_byte_i == cfg_i.code_first) begin
          kind_d = KIND_FIRST;
        end else if (data_byte_i == cfg_i.code_middle) begin
          kind_d = KIND_MIDDLE;
        end else if (data_byte_i == cfg_i.code_end) begin
          kind_d = KIND_END;
        end else begin
          kind_d = KIND_NONE;
          bad_d  = 1'b1;
        end
        if (kind_d == KIND_SINGLE || kind_d == KIND_FIRST) begin
          reasm_d     = 1'b0;
          exp_total_d = '0;
          fill_d      = '0;
          len_shift_d = '0;
        end else if (kind_d != KIND_NONE && !reasm_d) begin
          bad_d = 1'b1;
        end
        take = (kind_d == KIND_MIDDLE || kind_d == KIND_END) && (CONT_HDR_BYTES == 0);
      end else if (kind_q == KIND_SINGLE || kind_q == KIND_FIRST) begin
        if (32'(pos_q) < FIRST_HDR_BYTES) begin
          len_shift_d = {len_shift_q[23:0], data_byte_i};
          if (32'(pos_q) == FIRST_HDR_BYTES - 1) begin
            if (len_shift_d == 32'd0 || len_shift_d > eff_cap) begin
              bad_d = 1'b1;
            end else begin
              exp_total_d = LEN_W'(len_shift_d);
            end
          end
        end else begin
          take = 1'b1;
        end
      end else if (kind_q == KIND_MIDDLE || kind_q == KIND_END) begin
        take = (32'(pos_q) >= CONT_HDR_BYTES);
      end

      // Payload byte: write while below both the total and the buffer depth.
      if (take && !bad_d) begin
        if (fill_d < exp_total_d && 32'(fill_d) < BUFFER_DEPTH) begin
          store_wr_o.we   = 1'b1;
          store_wr_o.addr = BUF_AW'(fill_d);
          store_wr_o.data = data_byte_i;
          fill_d          = fill_d + LEN_W'(1);
        end else begin
          bad_d = 1'b1;
        end
      end

      if (32'(pos_q) < POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end

      if (pdu_last_i) begin
        if (kind_d == KIND_SINGLE || kind_d == KIND_FIRST) begin
          hdr_ok = (32'(pos_q) >= FIRST_HDR_BYTES - 1);
        end else begin
          hdr_ok = (32'(pos_q) + 32'd1 >= CONT_HDR_BYTES);
        end
        if (!bad_d && hdr_ok) begin
          unique case (kind_d)
            KIND_SINGLE, KIND_END: begin
              if (fill_d == exp_total_d) begin
                status_d = ST_DELIVER;
                len_d    = fill_d;
              end
            end
            KIND_FIRST: begin
              if (fill_d < exp_total_d) begin
                status_d    = ST_MORE;
                reasm_d     = 1'b1;
                last_time_d = frame_time_d;
              end
            end
            KIND_MIDDLE: begin
              status_d    = ST_MORE;
              last_time_d = frame_time_d;
            end
            default: status_d = ST_DROP;
          endcase
        end
        if (status_d == ST_DROP) begin
          reasm_d     = 1'b0;
          exp_total_d = '0;
          fill_d      = '0;
        end else if (status_d == ST_DELIVER) begin
          reasm_d = 1'b0;
        end
        pos_d  = '0;
        kind_d = KIND_NONE;
        bad_d  = 1'b0;
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reasm_q      <= 1'b0;
      exp_total_q  <= '0;
      fill_q       <= '0;
      last_time_q  <= '0;
      kind_q       <= KIND_NONE;
      pos_q        <= '0;
      len_shift_q  <= '0;
      frame_time_q <= '0;
      bad_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      reasm_q      <= reasm_d;
      exp_total_q  <= exp_total_d;
      fill_q       <= fill_d;
      last_time_q  <= last_time_d;
      kind_q       <= kind_d;
      pos_q        <= pos_d;
      len_shift_q  <= len_shift_d;
      frame_time_q <= frame_time_d;
      bad_q        <= bad_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      len_q     <= len_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign message_length_o = len_q;
  assign read_data_o      = (status_q == ST_READ && !rd_zero_q) ? store_rdata_i : 8'd0;

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= exp_total_q)
    else $error("fill count exceeds expected total");

  a_reasm_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reasm_q |-> (exp_total_q != '0))
    else $error("reassembly active with zero expected total");

  a_write_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr_o.we |-> (in_accept && !cmd_i && !store_rd_o.re))
    else $error("buffer write without an accepted PDU byte");

  a_deliver_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_DELIVER) |-> (len_q != '0))
    else $error("deliver with zero length");
`endif

endmodule

### rtl/core/fragment_reassembler.sv
`timescale 1ns / 1ps
// Latency: a result word is valid the cycle after its input word is accepted.
// Throughput: one input word per cycle unless a stalled result blocks it; each
// byte is one read-modify-write of the frame registers plus at most one
// access to the message buffer, which has one write port and one read port.
// PDU bytes that do not end their PDU are taken even while a result waits downstream.
// Reset: asynchronous, active low; control and configuration registers return
// to their defaults at once. The message buffer is not cleared, so no sweep.
// ----------------------------------------------------------------------------
// fragment_reassembler: first/middle/end frame reassembly
// Reassembles single, first, middle and end frames arriving one byte per word
// into a 1024-byte message buffer and reports need-more, deliver or drop at
// the end of each PDU. A read command returns one stored message byte.
// ----------------------------------------------------------------------------
module fragment_reassembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frasm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input word channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          pdu_last_i,
  input  logic [31:0]                   now_ms_i,
  input  logic [frasm_pkg::IDX_W-1:0]   read_index_i,
  // Result word channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [frasm_pkg::LEN_W-1:0]   message_length_o,
  output logic [7:0]                    read_data_o
);
  import frasm_pkg::*;

  // Live configuration, to be written by the user only while the block is idle; the block does not enforce this.
  cfg_t       cfg;
  // Buffer ports: the controller writes payload bytes at the fill count and
  // issues reads for the read command; the read data arrives in the cycle after,
  // exactly when the result register presents it.
  store_wr_t  store_wr;
  store_rd_t  store_rd;
  logic [7:0] store_rdata;

  frasm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Every word performs at most one buffer access, either a write or a read,
  // so a read never collides with a write in the same cycle, and a write is
  // visible to a read accepted on the very next cycle.
  frasm_store u_store (
    .clk_i   (clk_i),
    .wr_i    (store_wr),
    .rd_i    (store_rd),
    .rdata_o (store_rdata)
  );

  frasm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .data_byte_i      (data_byte_i),
    .pdu_last_i       (pdu_last_i),
    .now_ms_i         (now_ms_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .message_length_o (message_length_o),
    .read_data_o      (read_data_o),
    .store_wr_o       (store_wr),
    .store_rd_o       (store_rd),
    .store_rdata_i    (store_rdata)
  );

endmodule

### tb/tb_fragment_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fragment_reassembler: self-checking bench for the fragment reassembler
// Drives PDU bytes and store reads through the word channel, programs the
// registers over APB between phases, and checks every result word against a
// cycle-free predictor of the reassembly state kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_fragment_reassembler;
  import frasm_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Quiet cycles tolerated before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 5000;

  // The scoreboard holds its own copy of the configuration and the reassembly
  // state, predicts the result word of each accepted input word, and checks
  // the result words in order.
  class reassembly_scoreboard;
    typedef struct packed {
      status_e          status;
      logic [LEN_W-1:0] length;
      logic [7:0]       data;
    } result_t;

    result_t     expected_results[$];
    int unsigned mismatches;
    int unsigned high_water;

    logic [31:0]      timeout_limit;
    logic [LEN_W-1:0] capacity;
    logic [7:0]       code_single;
    logic [7:0]       code_first;
    logic [7:0]       code_middle;
    logic [7:0]       code_end;

    bit               reassembling;
    logic [LEN_W-1:0] expected_total;
    logic [LEN_W-1:0] fill_count;
    logic [31:0]      last_accept_ms;
    logic [31:0]      frame_ms;
    logic [31:0]      length_acc;
    kind_e            frame_kind;
    logic [POS_W-1:0] byte_pos;
    bit               frame_bad;
    logic [7:0]       msg_store [BUFFER_DEPTH];

    function new();
      timeout_limit  = 32'd0;
      capacity       = LEN_W'(BUFFER_DEPTH);
      code_single    = 8'd0;
      code_first     = 8'd1;
      code_middle    = 8'd2;
      code_end       = 8'd3;
      reassembling   = 1'b0;
      expected_total = '0;
      fill_count     = '0;
      last_accept_ms = 32'd0;
      frame_ms       = 32'd0;
      length_acc     = 32'd0;
      frame_kind     = KIND_NONE;
      byte_pos       = '0;
      frame_bad      = 1'b0;
      mismatches     = 0;
      high_water     = 0;
      foreach (msg_store[i]) msg_store[i] = 8'h00;
    endfunction

    function void set_register(logic [2:0] index, logic [31:0] value);
      case (index)
        REG_TIMEOUT:     timeout_limit = value;
        REG_CAPACITY:    capacity      = value[LEN_W-1:0];
        REG_CODE_SINGLE: code_single   = value[7:0];
        REG_CODE_FIRST:  code_first    = value[7:0];
        REG_CODE_MIDDLE: code_middle   = value[7:0];
        REG_CODE_END:    code_end      = value[7:0];
        default: ;
      endcase
    endfunction

    function void drop_reassembly();
      reassembling   = 1'b0;
      expected_total = '0;
      fill_count     = '0;
    endfunction

    // Payload goes to the store only while the frame is sound and the message
    // still has room; an extra byte spoils the frame instead.
    function void store_payload(logic [7:0] b);
      if (frame_bad) return;
      if (fill_count < expected_total && fill_count < BUFFER_DEPTH) begin
        msg_store[fill_count[BUF_AW-1:0]] = b;
        fill_count = fill_count + 1'b1;
        if (fill_count > high_water) high_water = fill_count;
      end else begin
        frame_bad = 1'b1;
      end
    endfunction

    function void note_word(bit cmd, logic [7:0] b, bit last, logic [31:0] stamp,
                            logic [IDX_W-1:0] index);
      result_t          r;
      logic [POS_W-1:0] p;
      int unsigned      cap;
      bit               head;
      bit               hdr_ok;
      r.status = ST_DROP;
      r.length = '0;
      r.data   = '0;
      if (cmd) begin
        r.status = ST_READ;
        r.data   = msg_store[index];
        expected_results.push_back(r);
        return;
      end
      p = byte_pos;
      if (p == 0) begin
        if (reassembling && timeout_limit != 0 && 32'(stamp - last_accept_ms) > timeout_limit)
          drop_reassembly();
        frame_ms  = stamp;
        frame_bad = 1'b0;
        if (b == code_single) frame_kind = KIND_SINGLE;
        else if (b == code_first) frame_kind = KIND_FIRST;
        else if (b == code_middle) frame_kind = KIND_MIDDLE;
        else if (b == code_end) frame_kind = KIND_END;
        else begin
          frame_kind = KIND_NONE;
          frame_bad  = 1'b1;
        end
        if (frame_kind == KIND_SINGLE || frame_kind == KIND_FIRST) begin
          drop_reassembly();
          length_acc = 32'd0;
        end else if (frame_kind != KIND_NONE && !reassembling) begin
          frame_bad = 1'b1;
        end
      end else if (frame_kind == KIND_SINGLE || frame_kind == KIND_FIRST) begin
        if (p < FIRST_HDR_BYTES) begin
          length_acc = (length_acc << 8) | 32'(b);
          if (p == FIRST_HDR_BYTES - 1) begin
            cap = (capacity < BUFFER_DEPTH) ? capacity : BUFFER_DEPTH;
            if (length_acc == 0 || length_acc > cap) frame_bad = 1'b1;
            else expected_total = length_acc[LEN_W-1:0];
          end
        end else begin
          store_payload(b);
        end
      end else if (frame_kind == KIND_MIDDLE || frame_kind == KIND_END) begin
        if (p >= CONT_HDR_BYTES) store_payload(b);
      end
      if (p < POS_MAX) byte_pos = p + 1'b1;
      if (!last) return;

      head   = (frame_kind == KIND_SINGLE || frame_kind == KIND_FIRST);
      hdr_ok = head ? (p >= FIRST_HDR_BYTES - 1) : (int'(p) + 1 >= CONT_HDR_BYTES);
      if (!frame_bad && hdr_ok && frame_kind != KIND_NONE) begin
        case (frame_kind)
          KIND_SINGLE, KIND_END: begin
            if (fill_count == expected_total) begin
              r.status = ST_DELIVER;
              r.length = fill_count;
            end
          end
          KIND_FIRST: begin
            if (fill_count < expected_total) begin
              r.status       = ST_MORE;
              reassembling   = 1'b1;
              last_accept_ms = frame_ms;
            end
          end
          default: begin
            r.status       = ST_MORE;
            last_accept_ms = frame_ms;
          end
        endcase
      end
      if (r.status == ST_DROP) drop_reassembly();
      else if (r.status == ST_DELIVER) reassembling = 1'b0;
      byte_pos   = '0;
      frame_kind = KIND_NONE;
      frame_bad  = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [LEN_W-1:0] length,
                               logic [7:0] data);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result word: status %0d length %0d data 0x%02h",
                   $time, status, length, data);
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status || length !== want.length || data !== want.data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: status %0d/%0d length %0d/%0d data 0x%02h/0x%02h %s",
                   $time, want.status, status, want.length, length, want.data, data,
                   "(expected/actual)");
      end
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [APB_AW-1:0]    paddr        = '0;
  logic [31:0]          pwdata       = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 cmd_i        = 1'b0;
  logic [7:0]           data_byte_i  = '0;
  logic                 pdu_last_i   = 1'b0;
  logic [31:0]          now_ms_i     = '0;
  logic [IDX_W-1:0]     read_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [1:0]           status_o;
  logic [LEN_W-1:0]     message_length_o;
  logic [7:0]           read_data_o;

  reassembly_scoreboard scoreboard;

  // Idling percentages of the current phase, the count of accepted input
  // words, the hang counter, and the millisecond clock that stamps control
  // bytes.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned items_sent      = 0;
  int unsigned quiet_cycles    = 0;
  logic [31:0] clock_ms        = 32'd0;

  always #5 clk_i = ~clk_i;

  fragment_reassembler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .data_byte_i      (data_byte_i),
    .pdu_last_i       (pdu_last_i),
    .now_ms_i         (now_ms_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .message_length_o (message_length_o),
    .read_data_o      (read_data_o)
  );

  // The receiver stalls at random with the phase's percentage; at zero it
  // takes every result word at once.
  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Result words are checked at the edge that accepts them. Outputs are
  // sampled before the edge's updates land, so the order of processes does not
  // matter.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      scoreboard.check_result(status_o, message_length_o, read_data_o);
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One APB write: a setup cycle, then the access cycle, which completes at
  // the first edge with pready high. The select stays high between the writes
  // of one burst, and the caller releases the bus after the last one.
  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    scoreboard.set_register(index, value);
  endtask

  task automatic configure(logic [31:0] timeout, logic [LEN_W-1:0] cap, logic [7:0] single,
                           logic [7:0] first, logic [7:0] middle, logic [7:0] last_code);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_CAPACITY, 32'(cap));
    write_reg(REG_CODE_SINGLE, 32'(single));
    write_reg(REG_CODE_FIRST, 32'(first));
    write_reg(REG_CODE_MIDDLE, 32'(middle));
    write_reg(REG_CODE_END, 32'(last_code));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one input word and returns at the edge that accepts it. A sender
  // gap lowers valid first; otherwise valid stays high into the next word, so
  // valid never gets two assignments in one step.
  task automatic send_word(bit cmd, logic [7:0] b, bit last, logic [31:0] stamp,
                           logic [IDX_W-1:0] index);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    data_byte_i  <= b;
    pdu_last_i   <= last;
    now_ms_i     <= stamp;
    read_index_i <= index;
    do @(posedge clk_i); while (!in_ready_o);
    scoreboard.note_word(cmd, b, last, stamp, index);
    items_sent++;
  endtask

  // Reads only ever target bytes already written, which always form the range
  // below the high-water mark. The unused fields carry noise.
  task automatic send_read();
    send_word(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), $urandom,
              IDX_W'($urandom_range(scoreboard.high_water - 1, 0)));
  endtask

  // Sends one PDU; the control byte carries the time stamp, and reads are
  // sometimes slipped in between its bytes.
  task automatic send_pdu(byte_q_t pdu, logic [31:0] stamp);
    foreach (pdu[i]) begin
      if (i != 0 && scoreboard.high_water != 0 && $urandom_range(99) < 4) send_read();
      send_word(1'b0, pdu[i], i == pdu.size() - 1, (i == 0) ? stamp : $urandom,
                IDX_W'($urandom_range(1023)));
    end
  endtask

  function automatic byte_q_t frame_header(logic [7:0] code, logic [31:0] total);
    byte_q_t pdu;
    pdu = {code, total[31:24], total[23:16], total[15:8], total[7:0]};
    return pdu;
  endfunction

  function automatic byte_q_t with_payload(byte_q_t pdu, int unsigned count);
    repeat (count) pdu.push_back(8'($urandom_range(255)));
    return pdu;
  endfunction

  function automatic int unsigned cap_limit();
    return (scoreboard.capacity < BUFFER_DEPTH) ? scoreboard.capacity : BUFFER_DEPTH;
  endfunction

  // Gaps between frames mostly stay within the timeout, and now and then sit
  // exactly on it or just past it. With the timeout off, any gap goes.
  function automatic logic [31:0] next_stamp();
    logic [31:0] lim;
    int unsigned r;
    lim = scoreboard.timeout_limit;
    r   = $urandom_range(99);
    if (lim == 0) clock_ms += $urandom;
    else if (r < 5) clock_ms += lim;
    else if (r < 12) clock_ms += lim + $urandom_range(3, 1);
    else clock_ms += $urandom_range((lim < 1000) ? lim : 1000, 0);
    return clock_ms;
  endfunction

  // A well-formed message: either one single frame, or a first frame followed
  // by up to two middle frames and an end frame, payload split at random.
  task automatic send_message();
    int unsigned cap;
    int unsigned total;
    int unsigned rem;
    int unsigned chunk;
    byte_q_t     pdu;
    cap   = cap_limit();
    total = ($urandom_range(9) == 0) ? $urandom_range((cap < 64) ? cap : 64, 1)
                                     : $urandom_range((cap < 16) ? cap : 16, 1);
    if (total == 1 || $urandom_range(2) == 0) begin
      send_pdu(with_payload(frame_header(scoreboard.code_single, total), total), next_stamp());
    end else begin
      chunk = $urandom_range(total - 1, 0);
      send_pdu(with_payload(frame_header(scoreboard.code_first, total), chunk), next_stamp());
      rem = total - chunk;
      repeat ($urandom_range(2)) begin
        chunk = $urandom_range(rem, 0);
        pdu   = {scoreboard.code_middle};
        send_pdu(with_payload(pdu, chunk), next_stamp());
        rem -= chunk;
      end
      pdu = {scoreboard.code_end};
      send_pdu(with_payload(pdu, rem), next_stamp());
    end
  endtask

  // Broken traffic: unknown codes, short headers, bad lengths, too much or
  // too little payload, a first frame that is already complete, stray
  // continuations, and a continuation arriving after the timeout.
  task automatic send_noise();
    int unsigned cap;
    int unsigned t;
    logic [31:0] total;
    byte_q_t     pdu;
    cap = cap_limit();
    t   = $urandom_range((cap < 8) ? cap : 8, 1);
    case ($urandom_range(7))
      0: begin
        pdu = {};
        pdu.push_back(8'($urandom_range(255)));
        send_pdu(with_payload(pdu, $urandom_range(5)), next_stamp());
      end
      1: begin
        pdu = {($urandom_range(1) != 0) ? scoreboard.code_single : scoreboard.code_first};
        send_pdu(with_payload(pdu, $urandom_range(3)), next_stamp());
      end
      2: begin
        case ($urandom_range(2))
          0:       total = 32'd0;
          1:       total = $urandom_range(2047, cap + 1);
          default: total = $urandom;
        endcase
        send_pdu(with_payload(frame_header(scoreboard.code_single, total), $urandom_range(3)),
                 next_stamp());
      end
      3: send_pdu(with_payload(frame_header(scoreboard.code_single, t), t + $urandom_range(3, 1)),
                  next_stamp());
      4: send_pdu(with_payload(frame_header(scoreboard.code_single, t), $urandom_range(t - 1, 0)),
                  next_stamp());
      5: send_pdu(with_payload(frame_header(scoreboard.code_first, t), t), next_stamp());
      6: begin
        pdu = {($urandom_range(1) != 0) ? scoreboard.code_middle : scoreboard.code_end};
        send_pdu(with_payload(pdu, $urandom_range(3)), next_stamp());
      end
      default: begin
        t = $urandom_range((cap < 8) ? cap : 8, (cap < 2) ? 1 : 2);
        send_pdu(with_payload(frame_header(scoreboard.code_first, t), $urandom_range(t - 1, 0)),
                 next_stamp());
        // Step past the timeout before the continuation.
        clock_ms += scoreboard.timeout_limit + $urandom_range(5, 1);
        pdu = {scoreboard.code_end};
        send_pdu(with_payload(pdu, $urandom_range(3)), clock_ms);
      end
    endcase
  endtask

  // Mostly whole messages with random content, the rest noise and reads.
  task automatic random_traffic(int unsigned count);
    int unsigned target;
    int unsigned r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 65) send_message();
      else if (r < 90) send_noise();
      else if (scoreboard.high_water != 0) repeat ($urandom_range(3, 1)) send_read();
    end
  endtask

  // Ends a phase: valid drops at the last acceptance edge, then the bench
  // waits for every result word and idles before the next phase.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (scoreboard.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned sender_pct, int unsigned recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  // Directed opening under the reset codes: unknown code, stray middle frame,
  // short header, zero length, a one-byte message, a read back, and a
  // two-frame message.
  task automatic directed_traffic();
    send_pdu({8'hFF}, 32'h0000_0000);
    send_pdu({scoreboard.code_middle}, 32'hFFFF_FFFF);
    send_pdu({scoreboard.code_single, 8'h00}, 32'd7);
    send_pdu(frame_header(scoreboard.code_single, 32'd0), 32'd8);
    send_pdu({scoreboard.code_single, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF}, 32'd9);
    send_read();
    send_pdu({scoreboard.code_first, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00}, 32'd10);
    send_pdu({scoreboard.code_end, 8'h5A}, 32'd11);
  endtask

  initial begin
    scoreboard = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration, no idling. One message of the full buffer size
    // fills the whole store, so later reads can reach every index.
    set_idling(0, 0);
    directed_traffic();
    send_pdu(with_payload(frame_header(scoreboard.code_single, BUFFER_DEPTH), BUFFER_DEPTH),
             next_stamp());
    random_traffic(80);
    drain();

    // Short timeout, high codes, sender gaps.
    configure(32'd100, 11'd1024, 8'hC0, 8'hC1, 8'hC2, 8'hFF);
    set_idling(56, 0);
    random_traffic(80);
    drain();

    // Largest timeout, smallest capacity, the clock wrapping; receiver stalls.
    configure(32'hFFFF_FFFF, 11'd1, 8'hFF, 8'h00, 8'h80, 8'h40);
    set_idling(0, 56);
    clock_ms = 32'hFFFF_FF00;
    random_traffic(80);
    drain();

    // Overlapping codes: first shadowed by single, end by middle. The timeout
    // of one millisecond makes continuations late now and then.
    configure(32'd1, 11'd17, 8'h07, 8'h07, 8'h09, 8'h09);
    set_idling(23, 23);
    random_traffic(80);
    drain();

    // Random settings.
    configure($urandom | 32'd1, LEN_W'($urandom_range(1024, 1)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    set_idling(0, 0);
    clock_ms = $urandom;
    random_traffic(80);
    drain();

    // Timeout off and the default codes again, for long reassembly runs.
    configure(32'd0, 11'd1024, 8'h00, 8'h01, 8'h02, 8'h03);
    set_idling(0, 56);
    random_traffic(80);
    drain();

    if (scoreboard.expected_results.size() != 0)
      $display("%0d result words never arrived", scoreboard.expected_results.size());
    if (scoreboard.mismatches == 0 && scoreboard.expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
